### rtl/core/assert_macros.svh
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, clk_s, rstn_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/srpq_pkg.sv
// Package: field widths, codes and controller/datapath handoff types.
`default_nettype none

package srpq_pkg;

  // Fixed widths of the channel fields
  localparam int CMD_W      = 2;
  localparam int ID_W       = 4;
  localparam int PRI_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  // Parameter defaults
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_PRIORITY_BITS = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Scan pointer operations
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LOAD_REAR,
    PTR_LOAD_FRONT,
    PTR_LOAD_NEXT,
    PTR_DEC,
    PTR_INC
  } ptr_op_t;

  // Memory write operations
  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT_UP,
    WR_SHIFT_DOWN,
    WR_NEW_ABOVE,
    WR_NEW_AT_ZERO
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    capture;
    ptr_op_t ptr_op;
    logic    rd_en;
    wr_op_t  wr_op;
    logic    take;
    cnt_op_t cnt_op;
    logic    st_load;
    status_t st_code;
    logic    out_load;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             rd_lt;
    logic             rd_hit;
    logic             rd_first;
    logic             rd_last;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/srpq_if.sv
// Channel interfaces: command input and result output.
`default_nettype none

interface srpq_in_if;
  logic                         valid;
  logic                         ready;
  logic [srpq_pkg::CMD_W-1:0]   command;
  logic [srpq_pkg::ID_W-1:0]    task_id;
  logic [srpq_pkg::PRI_W-1:0]   priority_req;

  modport source (output valid, command, task_id, priority_req, input ready);
  modport sink   (input valid, command, task_id, priority_req, output ready);
endinterface

interface srpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [srpq_pkg::STATUS_W-1:0] status;
  logic [srpq_pkg::ID_W-1:0]     out_task_id;
  logic [srpq_pkg::PRI_W-1:0]    out_priority;
  logic [srpq_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, out_task_id, out_priority, entry_count, input ready);
  modport sink   (input valid, status, out_task_id, out_priority, entry_count, output ready);
endinterface

`default_nettype wire

### rtl/core/srpq_dp.sv
// Datapath: entry memory, scan pointer, count and result register.
`default_nettype none

module srpq_dp #(
  parameter int QUEUE_DEPTH   = srpq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = srpq_pkg::DEF_PRIORITY_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire srpq_pkg::ctl_t                ctl,
  output srpq_pkg::sts_t                     sts,
  input  wire logic [srpq_pkg::CMD_W-1:0]    in_command,
  input  wire logic [srpq_pkg::ID_W-1:0]     in_task_id,
  input  wire logic [srpq_pkg::PRI_W-1:0]    in_priority_req,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [srpq_pkg::STATUS_W-1:0]      out_status,
  output logic [srpq_pkg::ID_W-1:0]          out_task_id,
  output logic [srpq_pkg::PRI_W-1:0]         out_priority,
  output logic [srpq_pkg::COUNT_W-1:0]       out_entry_count
);

  localparam int IdxW    = $clog2(QUEUE_DEPTH);
  localparam int CntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int IdW     = srpq_pkg::ID_W;
  localparam int PriOutW = srpq_pkg::PRI_W;
  localparam int CountOW = srpq_pkg::COUNT_W;
  localparam int EntryW  = IdW + PRIORITY_BITS;

  logic [EntryW-1:0]        mem [QUEUE_DEPTH];

  logic [srpq_pkg::CMD_W-1:0] cmd_r;
  logic [IdW-1:0]           req_id_r;
  logic [PRIORITY_BITS-1:0] req_pri_r;
  logic [IdxW-1:0]          ptr_r;
  logic [EntryW-1:0]        rdata_r;
  logic [IdxW-1:0]          rd_idx_r;
  logic [EntryW-1:0]        taken_r;
  logic [CntW-1:0]          count_r;
  srpq_pkg::status_t        st_r;
  logic                     out_valid_r;
  logic [srpq_pkg::STATUS_W-1:0] out_status_r;
  logic [IdW-1:0]           out_id_r;
  logic [PriOutW-1:0]       out_pri_r;
  logic [CountOW-1:0]       out_count_r;

  logic                     wr_en;
  logic [IdxW-1:0]          wr_addr;
  logic [EntryW-1:0]        wr_data;
  logic [IdxW-1:0]          ptr_nxt;
  logic [IdW-1:0]           rd_id;
  logic [PRIORITY_BITS-1:0] rd_pri;

  assign rd_id  = rdata_r[EntryW-1 -: IdW];
  assign rd_pri = rdata_r[PRIORITY_BITS-1:0];

  // Status toward the controller
  always_comb begin
    sts.cmd      = cmd_r;
    sts.full     = (count_r == CntW'(QUEUE_DEPTH));
    sts.empty    = (count_r == '0);
    sts.rd_lt    = (rd_pri < req_pri_r);
    sts.rd_hit   = (cmd_r == srpq_pkg::CMD_POP) || (rd_id == req_id_r);
    sts.rd_first = (rd_idx_r == '0);
    sts.rd_last  = ((CntW'(rd_idx_r) + CntW'(1)) == count_r);
    sts.out_free = !out_valid_r || out_ready;
  end

  // Decode the pointer operation
  always_comb begin
    unique case (ctl.ptr_op)
      srpq_pkg::PTR_HOLD:       ptr_nxt = ptr_r;
      srpq_pkg::PTR_LOAD_REAR:  ptr_nxt = IdxW'(count_r - CntW'(1));
      srpq_pkg::PTR_LOAD_FRONT: ptr_nxt = '0;
      srpq_pkg::PTR_LOAD_NEXT:  ptr_nxt = rd_idx_r + IdxW'(1);
      srpq_pkg::PTR_DEC:        ptr_nxt = ptr_r - IdxW'(1);
      srpq_pkg::PTR_INC:        ptr_nxt = ptr_r + IdxW'(1);
      default:                  ptr_nxt = ptr_r;
    endcase
  end

  // Decode the memory write
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = rdata_r;
    unique case (ctl.wr_op)
      srpq_pkg::WR_NONE:        wr_en = 1'b0;
      srpq_pkg::WR_SHIFT_UP:    wr_addr = rd_idx_r + IdxW'(1);
      srpq_pkg::WR_SHIFT_DOWN:  wr_addr = rd_idx_r - IdxW'(1);
      srpq_pkg::WR_NEW_ABOVE: begin
        wr_addr = rd_idx_r + IdxW'(1);
        wr_data = {req_id_r, req_pri_r};
      end
      srpq_pkg::WR_NEW_AT_ZERO: begin
        wr_addr = '0;
        wr_data = {req_id_r, req_pri_r};
      end
      default:                  wr_en = 1'b0;
    endcase
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r  <= mem[ptr_r];
      rd_idx_r <= ptr_r;
    end
  end

  // Request, pointer, taken entry and status code
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (ctl.capture) begin
      cmd_r     <= in_command;
      req_id_r  <= in_task_id;
      req_pri_r <= PRIORITY_BITS'(in_priority_req);
      taken_r   <= '0;
    end else if (ctl.take) begin
      taken_r   <= rdata_r;
    end
    if (ctl.st_load) begin
      st_r <= ctl.st_code;
    end
    if (ctl.out_load) begin
      out_status_r <= st_r;
      out_id_r     <= taken_r[EntryW-1 -: IdW];
      out_pri_r    <= PriOutW'(taken_r[PRIORITY_BITS-1:0]);
      out_count_r  <= CountOW'(count_r);
    end
  end

  // Entry count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (ctl.cnt_op)
        srpq_pkg::CNT_INC: count_r <= count_r + CntW'(1);
        srpq_pkg::CNT_DEC: count_r <= count_r - CntW'(1);
        default:           count_r <= count_r;
      endcase
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_task_id     = out_id_r;
  assign out_priority    = out_pri_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

### rtl/core/srpq_ctrl.sv
// Controller: sequences insert scans, searches and gap-closing shifts.
`default_nettype none

module srpq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire srpq_pkg::sts_t sts,
  output srpq_pkg::ctl_t      ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_SCAN,
    S_INS_FRONT,
    S_SRCH_RD,
    S_SRCH,
    S_RM_RD,
    S_RM_SHIFT,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.ptr_op  = srpq_pkg::PTR_HOLD;
    ctl.rd_en   = 1'b0;
    ctl.wr_op   = srpq_pkg::WR_NONE;
    ctl.take    = 1'b0;
    ctl.cnt_op  = srpq_pkg::CNT_HOLD;
    ctl.st_load = 1'b0;
    ctl.st_code = srpq_pkg::ST_DONE;
    ctl.out_load = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        case (sts.cmd) inside
          srpq_pkg::CMD_INSERT: begin
            if (sts.full) begin
              ctl.st_load = 1'b1;
              ctl.st_code = srpq_pkg::ST_FULL;
              state_nxt   = S_RESULT;
            end else if (sts.empty) begin
              ctl.wr_op   = srpq_pkg::WR_NEW_AT_ZERO;
              ctl.cnt_op  = srpq_pkg::CNT_INC;
              ctl.st_load = 1'b1;
              state_nxt   = S_RESULT;
            end else begin
              ctl.ptr_op  = srpq_pkg::PTR_LOAD_REAR;
              state_nxt   = S_INS_RD;
            end
          end
          srpq_pkg::CMD_POP, srpq_pkg::CMD_REMOVE: begin
            if (sts.empty) begin
              ctl.st_load = 1'b1;
              ctl.st_code = srpq_pkg::ST_MISS;
              state_nxt   = S_RESULT;
            end else begin
              ctl.ptr_op  = (sts.cmd == srpq_pkg::CMD_POP) ? srpq_pkg::PTR_LOAD_FRONT
                                                           : srpq_pkg::PTR_LOAD_REAR;
              state_nxt   = S_SRCH_RD;
            end
          end
          default: begin
            // Unused command: report done with no entry
            ctl.st_load = 1'b1;
            state_nxt   = S_RESULT;
          end
        endcase
      end

      S_INS_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.ptr_op = srpq_pkg::PTR_DEC;
        state_nxt  = S_INS_SCAN;
      end

      // Walk from the rear, moving lower priorities up one slot
      S_INS_SCAN: begin
        if (sts.rd_lt) begin
          ctl.wr_op = srpq_pkg::WR_SHIFT_UP;
          if (sts.rd_first) begin
            state_nxt = S_INS_FRONT;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.ptr_op = srpq_pkg::PTR_DEC;
          end
        end else begin
          ctl.wr_op   = srpq_pkg::WR_NEW_ABOVE;
          ctl.cnt_op  = srpq_pkg::CNT_INC;
          ctl.st_load = 1'b1;
          state_nxt   = S_RESULT;
        end
      end

      S_INS_FRONT: begin
        ctl.wr_op   = srpq_pkg::WR_NEW_AT_ZERO;
        ctl.cnt_op  = srpq_pkg::CNT_INC;
        ctl.st_load = 1'b1;
        state_nxt   = S_RESULT;
      end

      S_SRCH_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.ptr_op = srpq_pkg::PTR_DEC;
        state_nxt  = S_SRCH;
      end

      // Search from the rear; a pop hits on the front entry at once
      S_SRCH: begin
        if (sts.rd_hit) begin
          ctl.take = 1'b1;
          if (sts.rd_last) begin
            ctl.cnt_op  = srpq_pkg::CNT_DEC;
            ctl.st_load = 1'b1;
            state_nxt   = S_RESULT;
          end else begin
            ctl.ptr_op = srpq_pkg::PTR_LOAD_NEXT;
            state_nxt  = S_RM_RD;
          end
        end else if (sts.rd_first) begin
          ctl.st_load = 1'b1;
          ctl.st_code = srpq_pkg::ST_MISS;
          state_nxt   = S_RESULT;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.ptr_op = srpq_pkg::PTR_DEC;
        end
      end

      S_RM_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.ptr_op = srpq_pkg::PTR_INC;
        state_nxt  = S_RM_SHIFT;
      end

      // Close the gap, one entry down per cycle
      S_RM_SHIFT: begin
        ctl.wr_op = srpq_pkg::WR_SHIFT_DOWN;
        if (sts.rd_last) begin
          ctl.cnt_op  = srpq_pkg::CNT_DEC;
          ctl.st_load = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.ptr_op = srpq_pkg::PTR_INC;
        end
      end

      S_RESULT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/sorted_ring_priority_queue_top.sv
// Sorted priority queue: one command at a time, one result per command.
// An insert scans from the rear, shifting lower priorities up; a pop takes the front
// entry and a remove-by-id searches from the rear, both then closing any gap. The input
// stays closed until the result is loaded, so an output stall also holds new commands;
// the entry memory moves one entry per cycle during insert scans and shifts.
// Reset (synchronous, active low) empties the queue and drops any pending result.
`default_nettype none
`include "assert_macros.svh"

module sorted_ring_priority_queue_top #(
  parameter int QUEUE_DEPTH   = srpq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = srpq_pkg::DEF_PRIORITY_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  srpq_in_if.sink     in_chan,
  srpq_out_if.source  out_chan
);

  srpq_pkg::ctl_t ctl;
  srpq_pkg::sts_t sts;

  logic in_xfer;
  logic ins_wr;

  srpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  srpq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_chan.command),
    .in_task_id      (in_chan.task_id),
    .in_priority_req (in_chan.priority_req),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_status      (out_chan.status),
    .out_task_id     (out_chan.out_task_id),
    .out_priority    (out_chan.out_priority),
    .out_entry_count (out_chan.entry_count)
  );

  // Flag an input transfer and any write that places an inserted entry
  assign in_xfer = in_chan.valid && in_chan.ready;
  assign ins_wr  = ctl.wr_op inside {srpq_pkg::WR_SHIFT_UP, srpq_pkg::WR_NEW_ABOVE,
                                     srpq_pkg::WR_NEW_AT_ZERO};

  // One command in flight: a transfer closes the input until the result is loaded
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_xfer, !in_chan.ready, "input accepted twice")

  // A new result appears only after the controller left idle
  `ASSERT_IMPLIES(a_result_after_work, clk, rst_n, $rose(out_chan.valid), !$past(in_chan.ready), "result while idle")

  // A full queue never takes an insert write
  `ASSERT_IMPLIES(a_no_insert_when_full, clk, rst_n, sts.full, !ins_wr, "insert write when full")

  // Count never rises while an entry is being taken out
  `ASSERT_IMPLIES(a_take_no_inc, clk, rst_n, ctl.take, ctl.cnt_op != srpq_pkg::CNT_INC, "count raised on removal")

endmodule

`default_nettype wire
